// ===== rtl/ffaa_pkg.sv =====
package ffaa_pkg;

    localparam int unsigned TAG_BYTES  = 12;
    localparam int unsigned MIN_CHUNK  = 64;
    localparam int unsigned SIZE_GRAIN = 4;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_INVALID = 2'd1,
        ST_UNINIT  = 2'd2,
        ST_NOFIT   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_CALC,
        S_SPLIT,
        S_MARK
    } t_state;

    typedef enum logic {
        REG_HEAP_BASE  = 1'b0,
        REG_HEAP_BYTES = 1'b1
    } t_reg_idx;

    typedef struct packed {
        logic [31:0] request_bytes;
        logic [12:0] align_bytes;
    } t_request;

    typedef struct packed {
        t_status     status;
        logic [31:0] address;
    } t_result;

endpackage

// ===== rtl/first_fit_aligned_allocator.sv =====
// First-fit aligned heap allocator.
// Requests: i_request is taken at a rising edge with i_start high and
// o_busy low. Each request gives exactly one result on o_result, shown for
// a single cycle with o_done high; the receiver cannot stall, so results are
// never held back.
// Rejected requests (bad size or alignment, no heap) answer in the cycle
// after the transfer. A table walk reads the segment memory once per cycle
// along the linked list, visiting at most MAX_SEGMENTS segments; then S_CALC
// sizes the found segment, S_SPLIT writes the split entry and S_MARK the
// found entry back through the single write port. o_busy stays high until
// the result is given, so a request is taken only after the last is answered.
// Configuration: APB port, heap_base at 0x0, heap_bytes at 0x4. A write
// rebuilds the table as one free segment (none if heap_bytes is zero) in the
// following cycle, with o_busy high during it. Write only while idle.
// Reset: synchronous, active low; the table is empty and valid requests return
// the uninitialized status until heap_bytes is written nonzero.
module first_fit_aligned_allocator
    import ffaa_pkg::*;
#(
    parameter int MAX_SEGMENTS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  t_request    i_request,
    output logic        o_done,
    output t_result     o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int NW = $clog2(MAX_SEGMENTS + 1);
    localparam int EW = 65 + NW;

    logic [EW-1:0] r_mem [MAX_SEGMENTS];
    logic [EW-1:0] r_rd;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW-1:0] mem_raddr;
    logic [EW-1:0] mem_wdata;

    t_state        r_state, n_state;
    logic [31:0]   r_heap_base, r_heap_bytes;
    logic          r_rebuild, n_rebuild;
    logic [NW-1:0] r_count, n_count;
    logic [IW-1:0] r_idx, n_idx;
    logic [NW-1:0] r_steps, n_steps;
    logic [32:0]   r_size, n_size;
    logic [12:0]   r_align_m1, n_align_m1;
    logic [31:0]   r_f_start, n_f_start;
    logic [31:0]   r_f_size, n_f_size;
    logic [NW-1:0] r_f_next, n_f_next;
    logic [32:0]   r_chunk, n_chunk;
    logic [32:0]   r_aligned, n_aligned;
    logic [33:0]   r_end, n_end;
    logic [31:0]   r_used_len, n_used_len;
    logic [31:0]   r_rem, n_rem;
    logic          r_split, n_split;
    logic          r_done, n_done;
    t_result       r_result, n_result;

    logic          cfg_we;
    logic [31:0]   e_start, e_size;
    logic          e_used;
    logic [NW-1:0] e_next;
    logic [32:0]   w_chunk, w_aligned;
    logic [33:0]   w_end, w_limit, w_used_len;
    logic          w_fit;
    logic [12:0]   w_align;
    logic          w_bad;
    logic [31:0]   w_size_a, w_size0;
    logic [32:0]   w_room, w_room_t;

    assign cfg_we = psel & penable & pwrite;
    assign pready = 1'b1;
    assign prdata = (t_reg_idx'(paddr[2]) == REG_HEAP_BYTES) ? r_heap_bytes : r_heap_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base  <= '0;
            r_heap_bytes <= '0;
        end else if (cfg_we) begin
            if (t_reg_idx'(paddr[2]) == REG_HEAP_BYTES) begin
                r_heap_bytes <= pwdata;
            end else begin
                r_heap_base <= pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd <= r_mem[mem_raddr];
    end

    assign e_next  = r_rd[NW-1:0];
    assign e_used  = r_rd[NW];
    assign e_size  = r_rd[NW+32:NW+1];
    assign e_start = r_rd[NW+64:NW+33];

    assign w_chunk    = {1'b0, e_start} + 33'(TAG_BYTES);
    assign w_aligned  = (w_chunk + {20'd0, r_align_m1}) & ~{20'd0, r_align_m1};
    assign w_end      = {1'b0, w_aligned} + {1'b0, r_size};
    assign w_limit    = {1'b0, w_chunk} + {2'b0, e_size};
    assign w_fit      = !e_used && (w_end <= w_limit);
    assign w_used_len = r_end - {1'b0, r_chunk};

    assign w_align = i_request.align_bytes;
    assign w_bad   = (i_request.request_bytes == '0) || (w_align == '0)
                     || ((w_align & (w_align - 13'd1)) != '0);

    assign w_size_a = (r_heap_bytes > 32'(TAG_BYTES)) ? r_heap_bytes - 32'(TAG_BYTES) : '0;
    assign w_room   = 33'h1_0000_0000 - {1'b0, r_heap_base};
    assign w_room_t = (w_room > 33'(TAG_BYTES)) ? w_room - 33'(TAG_BYTES) : '0;
    assign w_size0  = (w_room_t < {1'b0, w_size_a}) ? w_room_t[31:0] : w_size_a;

    always_comb begin
        n_state    = r_state;
        n_rebuild  = r_rebuild | cfg_we;
        n_count    = r_count;
        n_idx      = r_idx;
        n_steps    = r_steps;
        n_size     = r_size;
        n_align_m1 = r_align_m1;
        n_f_start  = r_f_start;
        n_f_size   = r_f_size;
        n_f_next   = r_f_next;
        n_chunk    = r_chunk;
        n_aligned  = r_aligned;
        n_end      = r_end;
        n_used_len = r_used_len;
        n_rem      = r_rem;
        n_split    = r_split;
        n_done     = 1'b0;
        n_result   = r_result;
        mem_we     = 1'b0;
        mem_waddr  = r_idx;
        mem_wdata  = '0;
        mem_raddr  = '0;
        o_busy     = (r_state != S_IDLE) || r_rebuild;

        case (r_state)
            S_IDLE: begin
                if (r_rebuild) begin
                    n_rebuild = cfg_we;
                    mem_we    = 1'b1;
                    mem_waddr = '0;
                    mem_wdata = {r_heap_base, w_size0, 1'b0, NW'(MAX_SEGMENTS)};
                    n_count   = (r_heap_bytes == '0) ? '0 : NW'(1);
                end else if (i_start) begin
                    n_result.address = '0;
                    if (w_bad) begin
                        n_done          = 1'b1;
                        n_result.status = ST_INVALID;
                    end else if (r_count == '0) begin
                        n_done          = 1'b1;
                        n_result.status = ST_UNINIT;
                    end else begin
                        n_size     = ({1'b0, i_request.request_bytes} + 33'(SIZE_GRAIN - 1))
                                     & ~33'(SIZE_GRAIN - 1);
                        n_align_m1 = w_align - 13'd1;
                        n_idx      = '0;
                        n_steps    = '0;
                        mem_raddr  = '0;
                        n_state    = S_WALK;
                    end
                end
            end
            S_WALK: begin
                if (w_fit) begin
                    n_f_start = e_start;
                    n_f_size  = e_size;
                    n_f_next  = e_next;
                    n_chunk   = w_chunk;
                    n_aligned = w_aligned;
                    n_end     = w_end;
                    n_state   = S_CALC;
                end else if ((r_steps != NW'(MAX_SEGMENTS - 1)) && (e_next < r_count)) begin
                    n_steps   = r_steps + NW'(1);
                    n_idx     = e_next[IW-1:0];
                    mem_raddr = e_next[IW-1:0];
                end else begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_NOFIT, address: '0};
                    n_state  = S_IDLE;
                end
            end
            S_CALC: begin
                n_used_len = w_used_len[31:0];
                n_rem      = r_f_size - w_used_len[31:0];
                n_state    = S_SPLIT;
            end
            S_SPLIT: begin
                n_split = (r_rem > 32'(TAG_BYTES + MIN_CHUNK))
                          && (r_count < NW'(MAX_SEGMENTS));
                if (n_split) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[IW-1:0];
                    mem_wdata = {r_end[31:0], r_rem - 32'(TAG_BYTES), 1'b0, r_f_next};
                end
                n_state = S_MARK;
            end
            S_MARK: begin
                mem_we    = 1'b1;
                mem_waddr = r_idx;
                if (r_split) begin
                    mem_wdata = {r_f_start, r_used_len, 1'b1, r_count};
                    n_count   = r_count + NW'(1);
                end else begin
                    mem_wdata = {r_f_start, r_f_size, 1'b1, r_f_next};
                end
                n_done   = 1'b1;
                n_result = '{status: ST_OK, address: r_aligned[31:0]};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rebuild <= 1'b0;
            r_count   <= '0;
            r_done    <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rebuild <= n_rebuild;
            r_count   <= n_count;
            r_done    <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_steps    <= n_steps;
        r_size     <= n_size;
        r_align_m1 <= n_align_m1;
        r_f_start  <= n_f_start;
        r_f_size   <= n_f_size;
        r_f_next   <= n_f_next;
        r_chunk    <= n_chunk;
        r_aligned  <= n_aligned;
        r_end      <= n_end;
        r_used_len <= n_used_len;
        r_rem      <= n_rem;
        r_split    <= n_split;
        r_result   <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== dv/tb_first_fit_aligned_allocator.sv =====
`timescale 1ns / 1ps

module tb_first_fit_aligned_allocator;
    import ffaa_pkg::*;

    localparam int SEG_SLOTS = 64;
    localparam int ROUNDS    = 8;
    localparam int ROUND_LEN = 75;

    typedef enum {JOB_REQ, JOB_CFG, JOB_HOLD} t_job_kind;
    typedef enum {BUS_IDLE, BUS_SETUP, BUS_ACCESS} t_bus_phase;

    typedef struct {
        t_job_kind   kind;
        t_request    req;
        int unsigned gap_pct;
        t_reg_idx    reg_sel;
        logic [31:0] value;
    } t_job;

    logic        i_clk;
    logic        i_rst_n   = 1'b0;
    logic        i_start   = 1'b0;
    t_request    i_request = '0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic        o_busy;
    logic        o_done;
    t_result     o_result;
    logic [31:0] prdata;
    logic        pready;

    t_job        job_q[$];
    t_result     expected_q[$];
    t_job        cfg_job;
    t_bus_phase  bus_st = BUS_IDLE;

    // shadow of the segment table
    logic [31:0] base_shadow;
    logic [31:0] bytes_shadow;
    logic [31:0] blk_addr [SEG_SLOTS];
    logic [31:0] blk_len  [SEG_SLOTS];
    bit          blk_taken[SEG_SLOTS];
    int unsigned blk_link [SEG_SLOTS];
    int unsigned blk_cnt;

    int unsigned err_cnt;
    int unsigned status_tally[4];
    int unsigned split_cnt;
    int unsigned full_whole_cnt;
    int unsigned reg_writes;

    first_fit_aligned_allocator #(
        .MAX_SEGMENTS(SEG_SLOTS)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .o_busy   (o_busy),
        .i_request(i_request),
        .o_done   (o_done),
        .o_result (o_result),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    function automatic void heap_rebuild();
        longint unsigned first_len, room, hb;
        for (int i = 0; i < SEG_SLOTS; i++) begin
            blk_taken[i] = 1'b0;
        end
        if (bytes_shadow == 0) begin
            blk_cnt = 0;
            return;
        end
        hb = 64'(bytes_shadow);
        first_len = (hb > TAG_BYTES) ? hb - TAG_BYTES : 0;
        room = 64'h1_0000_0000;
        room = room - 64'(base_shadow);
        if (room > TAG_BYTES) room = room - TAG_BYTES;
        else room = 0;
        if (first_len > room) first_len = room;
        blk_addr[0]  = base_shadow;
        blk_len[0]   = first_len[31:0];
        blk_taken[0] = 1'b0;
        blk_link[0]  = SEG_SLOTS;
        blk_cnt      = 1;
    endfunction

    function automatic void heap_write(t_reg_idx sel, logic [31:0] v);
        if (sel == REG_HEAP_BASE) base_shadow = v;
        else bytes_shadow = v;
        heap_rebuild();
    endfunction

    function automatic t_result alloc_predict(t_request r);
        longint unsigned want_len, algn, chunk, aligned, pad, blk_sz;
        int unsigned     idx, hops, n;
        bit              hit;
        t_result         res;
        res.status  = ST_OK;
        res.address = '0;
        algn = 64'(r.align_bytes);
        if (r.request_bytes == 0 || algn == 0 || (algn & (algn - 1)) != 0) begin
            res.status = ST_INVALID;
            return res;
        end
        if (blk_cnt == 0) begin
            res.status = ST_UNINIT;
            return res;
        end
        want_len = 64'(r.request_bytes);
        want_len = (want_len + SIZE_GRAIN - 1) / SIZE_GRAIN * SIZE_GRAIN;
        idx  = 0;
        hops = 0;
        hit  = 1'b0;
        chunk   = 0;
        aligned = 0;
        blk_sz  = 0;
        while (!hit && hops < SEG_SLOTS && idx < blk_cnt) begin
            chunk   = 64'(blk_addr[idx]);
            chunk   = chunk + TAG_BYTES;
            aligned = (chunk + algn - 1) & ~(algn - 1);
            blk_sz  = 64'(blk_len[idx]);
            if (!blk_taken[idx] && aligned + want_len <= chunk + blk_sz) hit = 1'b1;
            else idx = blk_link[idx];
            hops++;
        end
        if (!hit) begin
            res.status = ST_NOFIT;
            return res;
        end
        pad = aligned - chunk;
        if (blk_sz - want_len - pad > TAG_BYTES + MIN_CHUNK) begin
            if (blk_cnt < SEG_SLOTS) begin
                n = blk_cnt;
                blk_addr[n]  = 32'(aligned + want_len);
                blk_len[n]   = 32'(blk_sz - (TAG_BYTES + pad + want_len));
                blk_taken[n] = 1'b0;
                blk_link[n]  = blk_link[idx];
                blk_len[idx] = 32'(pad + want_len);
                blk_link[idx] = n;
                blk_cnt = n + 1;
                split_cnt++;
            end else begin
                full_whole_cnt++;
            end
        end
        blk_taken[idx] = 1'b1;
        res.address = aligned[31:0];
        return res;
    endfunction

    function automatic t_request rand_request();
        t_request    r;
        int unsigned pick;
        pick = $urandom_range(99);
        r.request_bytes = $urandom_range(1, 64);
        r.align_bytes   = 13'd1 << $urandom_range(0, 4);
        if (pick >= 45 && pick < 65) begin
            r.request_bytes = $urandom_range(1, 1024);
            r.align_bytes   = 13'd1 << $urandom_range(0, 12);
        end else if (pick >= 65 && pick < 75) begin
            r.request_bytes = $urandom_range(1, 32'h0001_0000);
            r.align_bytes   = 13'd1 << $urandom_range(0, 12);
        end else if (pick >= 75 && pick < 85) begin
            r.request_bytes = $urandom;
            r.align_bytes   = 13'($urandom_range(0, 4096));
        end else if (pick >= 85 && pick < 92) begin
            r.align_bytes = 13'd3 << $urandom_range(0, 10);
        end else if (pick >= 92) begin
            r.request_bytes = '0;
        end
        return r;
    endfunction

    task automatic queue_req(input logic [31:0] nbytes, input logic [12:0] algn,
                             input int unsigned gap);
        t_job j;
        j.kind    = JOB_REQ;
        j.req.request_bytes = nbytes;
        j.req.align_bytes   = algn;
        j.gap_pct = gap;
        j.reg_sel = REG_HEAP_BASE;
        j.value   = '0;
        job_q.push_back(j);
    endtask

    task automatic queue_cfg(input t_reg_idx sel, input logic [31:0] v);
        t_job j;
        j.kind    = JOB_CFG;
        j.req     = '0;
        j.gap_pct = 0;
        j.reg_sel = sel;
        j.value   = v;
        job_q.push_back(j);
    endtask

    task automatic queue_hold();
        t_job j;
        j.kind    = JOB_HOLD;
        j.req     = '0;
        j.gap_pct = 0;
        j.reg_sel = REG_HEAP_BASE;
        j.value   = '0;
        job_q.push_back(j);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // request and register driver
    always @(posedge i_clk) begin : drive
        t_job job;
        logic start_nxt;
        bit   settled;
        if (!i_rst_n) begin
            i_start <= 1'b0;
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            bus_st  <= BUS_IDLE;
        end else begin
            start_nxt = i_start;
            if (i_start && !o_busy) begin
                expected_q.push_back(alloc_predict(i_request));
                start_nxt = 1'b0;
            end
            settled = !start_nxt && expected_q.size() == 0 && o_done !== 1'b1;
            case (bus_st)
                BUS_SETUP: begin
                    penable <= 1'b1;
                    bus_st  <= BUS_ACCESS;
                end
                BUS_ACCESS: begin
                    if (pready) begin
                        heap_write(cfg_job.reg_sel, cfg_job.value);
                        reg_writes++;
                        psel    <= 1'b0;
                        penable <= 1'b0;
                        pwrite  <= 1'b0;
                        bus_st  <= BUS_IDLE;
                    end
                end
                default: begin
                    if (!start_nxt && job_q.size() != 0) begin
                        job = job_q[0];
                        case (job.kind)
                            JOB_REQ: begin
                                if ($urandom_range(99) >= job.gap_pct) begin
                                    start_nxt = 1'b1;
                                    i_request <= job.req;
                                    void'(job_q.pop_front());
                                end
                            end
                            JOB_HOLD: begin
                                if (settled) void'(job_q.pop_front());
                            end
                            default: begin
                                if (settled && !o_busy) begin
                                    cfg_job = job;
                                    psel    <= 1'b1;
                                    penable <= 1'b0;
                                    pwrite  <= 1'b1;
                                    paddr   <= {job.reg_sel, 2'b00};
                                    pwdata  <= job.value;
                                    bus_st  <= BUS_SETUP;
                                    void'(job_q.pop_front());
                                end
                            end
                        endcase
                    end
                end
            endcase
            i_start <= start_nxt;
        end
    end

    // result checker
    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && o_done === 1'b1) begin
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: status %0d address %h",
                       o_result.status, o_result.address);
                err_cnt++;
            end else begin
                want = expected_q.pop_front();
                status_tally[want.status]++;
                if (o_result.status !== want.status) begin
                    $error("status mismatch: expected %0d got %0d",
                           want.status, o_result.status);
                    err_cnt++;
                end
                if (o_result.address !== want.address) begin
                    $error("address mismatch: expected %h got %h",
                           want.address, o_result.address);
                    err_cnt++;
                end
            end
        end
    end

    initial begin
        logic [31:0] rnd_base [ROUNDS];
        logic [31:0] rnd_bytes[ROUNDS];
        t_request    rq;
        int unsigned gap;

        base_shadow  = '0;
        bytes_shadow = '0;
        blk_cnt      = 0;
        for (int i = 0; i < SEG_SLOTS; i++) begin
            blk_taken[i] = 1'b0;
        end

        // no heap yet: argument checks come first
        queue_req(32'd0, 13'd4, 12);
        queue_req(32'd16, 13'd0, 12);
        queue_req(32'd16, 13'd12, 12);
        queue_req(32'd16, 13'd4, 12);

        queue_cfg(REG_HEAP_BASE, 32'h1000_0000);
        queue_cfg(REG_HEAP_BYTES, 32'h0000_1000);
        queue_req(32'd1, 13'd1, 12);
        queue_req(32'd3, 13'd2, 12);
        queue_req(32'hFFFF_FFFF, 13'd4096, 12);
        queue_req(32'd100, 13'd4096, 12);
        queue_req(32'd64, 13'd64, 12);
        queue_req(32'd8, 13'd4095, 12);
        for (int b = 3; b < 12; b++) begin
            queue_req(32'd4, 13'd1 << b, 12);
        end

        // heap no larger than one tag
        queue_cfg(REG_HEAP_BYTES, 32'd12);
        queue_req(32'd4, 13'd4, 12);

        // top of the address space
        queue_cfg(REG_HEAP_BASE, 32'hFFFF_F000);
        queue_cfg(REG_HEAP_BYTES, 32'hFFFF_F000);
        queue_req(32'd4084, 13'd4, 12);
        queue_req(32'd4, 13'd4, 12);

        queue_cfg(REG_HEAP_BYTES, 32'd0);
        queue_req(32'd4, 13'd4, 12);

        rnd_base[0] = 32'h1000_0000;  rnd_bytes[0] = 32'h0001_0000;
        rnd_base[1] = 32'h0000_0000;  rnd_bytes[1] = 32'hFFFF_F000;
        rnd_base[2] = 32'hFFFF_F000;  rnd_bytes[2] = 32'hFFFF_F000;
        rnd_base[3] = 32'h0000_0ABC;  rnd_bytes[3] = 32'h0000_1FFF;
        rnd_base[4] = 32'h8000_0000;  rnd_bytes[4] = 32'h0000_2000;
        rnd_base[5] = {20'($urandom_range(0, 20'hFFFFE)), 12'h000};
        rnd_bytes[5] = 32'h0000_4000;
        rnd_base[6] = 32'h7FFF_F000;  rnd_bytes[6] = 32'h0010_0000;
        rnd_base[7] = 32'h0000_4000;  rnd_bytes[7] = 32'h0000_8000;

        for (int r = 0; r < ROUNDS; r++) begin
            gap = (r < 3) ? 12 : (r < 6) ? 73 : 0;
            queue_cfg(REG_HEAP_BASE, rnd_base[r]);
            queue_cfg(REG_HEAP_BYTES, rnd_bytes[r]);
            for (int k = 0; k < ROUND_LEN; k++) begin
                if (k == 40) begin
                    // odd rounds clear the table through a base rewrite
                    if (r % 2) queue_cfg(REG_HEAP_BASE, rnd_base[r]);
                    else queue_hold();
                end
                rq = rand_request();
                queue_req(rq.request_bytes, rq.align_bytes, gap);
            end
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (job_q.size() != 0 || i_start || psel || expected_q.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);

        if (expected_q.size() != 0) begin
            $error("%0d results never arrived", expected_q.size());
            err_cnt++;
        end
        $display("requests %0d: granted %0d, invalid %0d, no heap %0d, no fit %0d",
                 status_tally[0] + status_tally[1] + status_tally[2] + status_tally[3],
                 status_tally[ST_OK], status_tally[ST_INVALID],
                 status_tally[ST_UNINIT], status_tally[ST_NOFIT]);
        $display("segment splits %0d, unsplit grants on a full table %0d, reg writes %0d",
                 split_cnt, full_whole_cnt, reg_writes);
        if (err_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/ffaa_pkg.sv
rtl/first_fit_aligned_allocator.sv
dv/tb_first_fit_aligned_allocator.sv
